[design/cbd_pkg.sv]
// cbd_pkg: shared types and constants of the chunked body deframer.
// No dependencies; used by cbd_core, cbd_out_stage, the top level and the bench.
package cbd_pkg;

    localparam int unsigned MAX_SIZE_LINE = 16;   // size line limit, CR LF included
    localparam int unsigned HC_W          = 5;    // header char counter width

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_FIXED   = 2'd1;
    localparam logic [1:0] MODE_CHUNKED = 2'd2;

    localparam logic CFG_FRAMING_MODE = 1'b0;
    localparam logic CFG_BODY_LENGTH  = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_SIZE    = 2'd0,
        PH_DATA    = 2'd1,
        PH_TAIL_CR = 2'd2,
        PH_TAIL_LF = 2'd3
    } t_phase;

    // one result beat
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

    // configuration write
    typedef struct packed {
        logic        we;
        logic        idx;
        logic [31:0] data;
    } t_cfg;

endpackage

[design/cbd_in_stage.sv]
// cbd_in_stage: input register of the deframer, holds one received beat.
// Standalone; uses no package items.
module cbd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_advance,   // core consumes the held beat this cycle
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

[design/cbd_core.sv]
// cbd_core: framing state and the per-beat decode step (raw, fixed, chunked).
// Depends on cbd_pkg.
module cbd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbd_pkg::t_cfg   i_cfg,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output cbd_pkg::t_result o_res
);

    logic [1:0]                  r_mode;
    logic [31:0]                 r_body_length;
    cbd_pkg::t_phase             r_phase;
    logic [31:0]                 r_chunk_size;
    logic [31:0]                 r_bytes_done;
    logic [cbd_pkg::HC_W-1:0]    r_header_chars;
    logic                        r_saw_cr;
    logic                        r_hex_stopped;
    logic                        r_last_zero;

    cbd_pkg::t_phase             n_phase;
    logic [31:0]                 n_chunk_size;
    logic [31:0]                 n_bytes_done;
    logic [cbd_pkg::HC_W-1:0]    n_header_chars;
    logic                        n_saw_cr;
    logic                        n_hex_stopped;
    logic                        n_last_zero;

    logic [31:0]                 bytes_inc;
    logic [cbd_pkg::HC_W-1:0]    hc_inc;
    logic [4:0]                  hv;
    logic                        err;

    // 0..15 for a hex digit, 16 otherwise
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
        if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
        return v;
    endfunction

    assign bytes_inc = r_bytes_done + 32'd1;
    assign hc_inc    = r_header_chars + {{(cbd_pkg::HC_W-1){1'b0}}, 1'b1};
    assign hv        = hex_value(i_byte);

    always_comb begin
        n_phase        = r_phase;
        n_chunk_size   = r_chunk_size;
        n_bytes_done   = r_bytes_done;
        n_header_chars = r_header_chars;
        n_saw_cr       = r_saw_cr;
        n_hex_stopped  = r_hex_stopped;
        n_last_zero    = r_last_zero;
        err            = 1'b0;
        o_res.valid    = 1'b0;
        o_res.data     = 8'd0;
        o_res.kind     = cbd_pkg::KIND_PAYLOAD;
        o_res.last     = 1'b0;

        case (r_mode)
            cbd_pkg::MODE_CHUNKED: begin
                case (r_phase)
                    cbd_pkg::PH_SIZE: begin
                        if (r_saw_cr && i_byte == cbd_pkg::CH_LF) begin
                            n_header_chars = '0;
                            n_saw_cr       = 1'b0;
                            n_hex_stopped  = 1'b0;
                            n_bytes_done   = 32'd0;
                            if (r_chunk_size == 32'd0) begin
                                n_last_zero = 1'b1;
                                n_phase     = cbd_pkg::PH_TAIL_CR;
                            end else begin
                                n_phase = cbd_pkg::PH_DATA;
                            end
                        end else if (hc_inc >= cbd_pkg::HC_W'(cbd_pkg::MAX_SIZE_LINE)) begin
                            err = 1'b1;
                        end else begin
                            n_header_chars = hc_inc;
                            n_saw_cr       = (i_byte == cbd_pkg::CH_CR);
                            if (!r_hex_stopped) begin
                                if (hv < 5'd16) begin
                                    if (r_chunk_size[31:28] != 4'd0) begin
                                        err = 1'b1;   // size past 32 bits
                                    end else begin
                                        n_chunk_size = {r_chunk_size[27:0], hv[3:0]};
                                    end
                                end else begin
                                    n_hex_stopped = 1'b1;   // extensions follow
                                end
                            end
                        end
                    end
                    cbd_pkg::PH_DATA: begin
                        n_bytes_done = bytes_inc;
                        if (bytes_inc >= r_chunk_size) begin
                            n_phase = cbd_pkg::PH_TAIL_CR;
                        end
                        o_res.valid = 1'b1;
                        o_res.data  = i_byte;
                    end
                    cbd_pkg::PH_TAIL_CR: begin
                        if (i_byte != cbd_pkg::CH_CR) begin
                            err = 1'b1;
                        end else begin
                            n_phase = cbd_pkg::PH_TAIL_LF;
                        end
                    end
                    default: begin
                        if (i_byte != cbd_pkg::CH_LF) begin
                            err = 1'b1;
                        end else begin
                            n_phase        = cbd_pkg::PH_SIZE;
                            n_chunk_size   = 32'd0;
                            n_bytes_done   = 32'd0;
                            n_header_chars = '0;
                            n_saw_cr       = 1'b0;
                            n_hex_stopped  = 1'b0;
                            n_last_zero    = 1'b0;
                            if (r_last_zero) begin
                                o_res.valid = 1'b1;
                                o_res.kind  = cbd_pkg::KIND_END;
                            end
                        end
                    end
                endcase
                if (err) begin
                    n_phase        = cbd_pkg::PH_SIZE;
                    n_chunk_size   = 32'd0;
                    n_bytes_done   = 32'd0;
                    n_header_chars = '0;
                    n_saw_cr       = 1'b0;
                    n_hex_stopped  = 1'b0;
                    n_last_zero    = 1'b0;
                    o_res.valid    = 1'b1;
                    o_res.data     = 8'd0;
                    o_res.kind     = cbd_pkg::KIND_ERROR;
                end
            end
            cbd_pkg::MODE_FIXED: begin
                if (r_body_length == 32'd0) begin
                    o_res.valid = 1'b1;
                    o_res.data  = i_byte;
                end else if (r_bytes_done < r_body_length) begin
                    n_bytes_done = bytes_inc;
                    o_res.valid  = 1'b1;
                    o_res.data   = i_byte;
                    o_res.last   = (bytes_inc == r_body_length);
                end
            end
            default: begin
                // raw, and unused mode 3
                o_res.valid = 1'b1;
                o_res.data  = i_byte;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= cbd_pkg::MODE_RAW;
            r_body_length  <= 32'd0;
            r_phase        <= cbd_pkg::PH_SIZE;
            r_chunk_size   <= 32'd0;
            r_bytes_done   <= 32'd0;
            r_header_chars <= '0;
            r_saw_cr       <= 1'b0;
            r_hex_stopped  <= 1'b0;
            r_last_zero    <= 1'b0;
        end else if (i_cfg.we) begin
            if (i_cfg.idx == cbd_pkg::CFG_FRAMING_MODE) begin
                r_mode         <= i_cfg.data[1:0];
                r_phase        <= cbd_pkg::PH_SIZE;
                r_chunk_size   <= 32'd0;
                r_bytes_done   <= 32'd0;
                r_header_chars <= '0;
                r_saw_cr       <= 1'b0;
                r_hex_stopped  <= 1'b0;
                r_last_zero    <= 1'b0;
            end else begin
                r_body_length <= i_cfg.data;
                if (r_mode != cbd_pkg::MODE_CHUNKED) begin
                    r_bytes_done <= 32'd0;
                end
            end
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_chunk_size   <= n_chunk_size;
            r_bytes_done   <= n_bytes_done;
            r_header_chars <= n_header_chars;
            r_saw_cr       <= n_saw_cr;
            r_hex_stopped  <= n_hex_stopped;
            r_last_zero    <= n_last_zero;
        end
    end

    // an error beat always leaves a clean size-line state behind
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg.we && o_res.valid && o_res.kind == cbd_pkg::KIND_ERROR)
        |=> (r_phase == cbd_pkg::PH_SIZE && r_chunk_size == 32'd0
             && r_header_chars == '0))
        else $error("cbd_core: state not cleared after framing error");

    // header counter never reaches the line limit
    a_hc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_chars < cbd_pkg::HC_W'(cbd_pkg::MAX_SIZE_LINE))
        else $error("cbd_core: size line counter out of range");

    // while passing chunk data, the count stays below the chunk size
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == cbd_pkg::MODE_CHUNKED && r_phase == cbd_pkg::PH_DATA)
        |-> (r_bytes_done < r_chunk_size))
        else $error("cbd_core: chunk data count past chunk size");

    // last flag only on payload beats
    a_last_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.kind == cbd_pkg::KIND_PAYLOAD))
        else $error("cbd_core: last flag on non-payload result");

endmodule

[design/cbd_out_stage.sv]
// cbd_out_stage: result register toward the master-side stream.
// Depends on cbd_pkg.
module cbd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,    // core produces a result this cycle
    input  cbd_pkg::t_result i_res,
    output logic             o_free,    // slot can take a result this cycle
    input  logic             i_ready,
    output cbd_pkg::t_result o_res
);

    logic             r_valid;
    cbd_pkg::t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        o_res       = r_res;
        o_res.valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[design/chunked_body_deframer.sv]
// chunked_body_deframer: top level of the body deframer.
// Depends on cbd_pkg, cbd_in_stage, cbd_core, cbd_out_stage.
//
// Strips body framing from a received byte stream, one byte per slave beat.
// framing_mode (cfg index 0) selects raw passthrough (0, also 3), fixed length
// (1) or chunked coding (2); writing it clears the framing state. body_length
// (cfg index 1) is the fixed-length byte limit, zero meaning unlimited; writing
// it restarts the fixed-length count. Write configuration only while idle.
// Each input beat yields zero or one master beat: tdata[7:0] the payload byte
// (zero unless payload), tuser[1:0] the kind (0 payload, 1 end of body, 2 framing
// error), tlast marks the final byte of a fixed-length body. Chunked mode drops
// size lines and CR LF tails, ends a body on a zero-size chunk, and reports
// over-long size lines, size overflow and bad tails as errors, then resumes at
// the next size line. Throughput is one beat per clock while the master side
// accepts; a slave beat passes the input register, the combinational decode
// step and the result register on its way to the master side.
module chunked_body_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] data_byte
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast     // last_of_body
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             out_free;
    logic             step;
    cbd_pkg::t_cfg    cfg;
    cbd_pkg::t_result core_res;
    cbd_pkg::t_result out_res;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // the held beat is decoded whenever the result slot can take its outcome
    assign step = in_valid && out_free;

    cbd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_byte    (s_tdata),
        .i_advance (step),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    cbd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_byte  (in_byte),
        .o_res   (core_res)
    );

    cbd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && core_res.valid),
        .i_res   (core_res),
        .o_free  (out_free),
        .i_ready (m_tready),
        .o_res   (out_res)
    );

    assign m_tvalid = out_res.valid;
    assign m_tdata  = out_res.data;
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_res.last;

endmodule

[test/tb_chunked_body_deframer.sv]
// tb_chunked_body_deframer: self-checking bench for the chunked body deframer.
// Drives raw, fixed-length and chunked byte streams and compares every result
// beat against a behavioral predictor kept in this file. Needs cbd_pkg and the RTL.
`timescale 1ns / 100ps

module tb_chunked_body_deframer;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         SETTLE_CYCLES = 6;      // outlasts the input and result registers
    localparam int         RANDOM_BYTES  = 1300;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;   // decodes as raw passthrough

    typedef enum logic [1:0] {ROW_BYTE, ROW_MODE, ROW_LEN} t_row_op;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} t_row_chk;

    typedef struct packed {
        logic [7:0]     data;
        cbd_pkg::t_kind kind;
        logic           last;
    } t_body_beat;

    typedef struct packed {
        t_row_op        op;
        logic [31:0]    val;
        t_row_chk       chk;
        logic [7:0]     data;
        cbd_pkg::t_kind kind;
        logic           last;
    } t_stim_row;

    localparam int N_ROWS = 31;
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        // raw mode straight out of reset, both byte extremes
        '{ROW_BYTE, 32'h00, CHK_TYPED, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'hFF, CHK_TYPED, 8'hFF, cbd_pkg::KIND_PAYLOAD, 1'b0},
        // unused mode code passes bytes like raw
        '{ROW_MODE, 32'(MODE_UNUSED), CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h0D, CHK_TYPED, 8'h0D, cbd_pkg::KIND_PAYLOAD, 1'b0},
        // fixed length of two: second byte is last, third is dropped
        '{ROW_MODE, 32'(cbd_pkg::MODE_FIXED), CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_LEN,  32'd2, CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'hA5, CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h5A, CHK_TYPED, 8'h5A, cbd_pkg::KIND_PAYLOAD, 1'b1},
        '{ROW_BYTE, 32'h33, CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        // zero length means unlimited, then the largest length
        '{ROW_LEN,  32'd0, CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h80, CHK_TYPED, 8'h80, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_LEN,  32'hFFFF_FFFF, CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h01, CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        // chunked: "1;x" CR LF, one payload byte, CR LF tail
        '{ROW_MODE, 32'(cbd_pkg::MODE_CHUNKED), CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h31, CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h3B, CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h78, CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_CR), CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_LF), CHK_NONE, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h77, CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_CR), CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_LF), CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        // size line with no digit is a last chunk; its tail ends the body
        '{ROW_BYTE, 32'(cbd_pkg::CH_CR), CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_LF), CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_CR), CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_LF), CHK_TYPED, 8'h00, cbd_pkg::KIND_END, 1'b0},
        // bad tail after chunk data
        '{ROW_BYTE, 32'h31, CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_CR), CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'(cbd_pkg::CH_LF), CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h51, CHK_MODEL, 8'h00, cbd_pkg::KIND_PAYLOAD, 1'b0},
        '{ROW_BYTE, 32'h5A, CHK_TYPED, 8'h00, cbd_pkg::KIND_ERROR, 1'b0}
    };

    // ---------------------------------------------------------------- DUT I/O
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = cbd_pkg::CFG_FRAMING_MODE;
    logic [31:0] i_cfg_data = '0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata    = '0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    chunked_body_deframer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------ deframer predictor
    logic [1:0]      mode_q     = cbd_pkg::MODE_RAW;
    logic [31:0]     len_q      = '0;
    cbd_pkg::t_phase ph         = cbd_pkg::PH_SIZE;
    logic [31:0]     size_acc   = '0;    // hex size being parsed / current chunk size
    logic [31:0]     rx_count   = '0;    // bytes passed in chunk or fixed body
    logic [4:0]      line_len   = '0;
    logic            cr_seen    = 1'b0;
    logic            hex_done   = 1'b0;
    logic            zero_chunk = 1'b0;

    t_body_beat  body_q[$];          // beats still owed by the DUT
    t_body_beat  head_beat;
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    int          sent_cnt     = 0;
    bit          steady       = 1'b0;  // no idling on either side while set

    task automatic clear_framing();
        ph         = cbd_pkg::PH_SIZE;
        size_acc   = '0;
        rx_count   = '0;
        line_len   = '0;
        cr_seen    = 1'b0;
        hex_done   = 1'b0;
        zero_chunk = 1'b0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, output bit produced,
                                output t_body_beat beat);
        logic [4:0] nib;
        bit         err;
        err      = 1'b0;
        produced = 1'b0;
        beat     = '{data: 8'h00, kind: cbd_pkg::KIND_PAYLOAD, last: 1'b0};
        if (mode_q == cbd_pkg::MODE_CHUNKED) begin
            case (ph)
                cbd_pkg::PH_SIZE: begin
                    if (cr_seen && b == cbd_pkg::CH_LF) begin
                        line_len = '0;
                        cr_seen  = 1'b0;
                        hex_done = 1'b0;
                        rx_count = '0;
                        if (size_acc == 32'd0) begin
                            zero_chunk = 1'b1;
                            ph         = cbd_pkg::PH_TAIL_CR;
                        end else begin
                            ph = cbd_pkg::PH_DATA;
                        end
                    end else begin
                        line_len = line_len + 5'd1;
                        if (line_len >= 5'(cbd_pkg::MAX_SIZE_LINE)) begin
                            err = 1'b1;
                        end else begin
                            cr_seen = (b == cbd_pkg::CH_CR);
                            if (b >= 8'h30 && b <= 8'h39)
                                nib = {1'b0, b[3:0]};
                            else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
                                nib = {1'b0, b[3:0]} + 5'd9;
                            else
                                nib = 5'd16;
                            // digits only count up to the first non-hex char
                            if (!hex_done) begin
                                if (nib < 5'd16) begin
                                    if (size_acc[31:28] != 4'd0)
                                        err = 1'b1;
                                    else
                                        size_acc = {size_acc[27:0], nib[3:0]};
                                end else begin
                                    hex_done = 1'b1;
                                end
                            end
                        end
                    end
                end
                cbd_pkg::PH_DATA: begin
                    rx_count = rx_count + 32'd1;
                    if (rx_count >= size_acc)
                        ph = cbd_pkg::PH_TAIL_CR;
                    produced  = 1'b1;
                    beat.data = b;
                end
                cbd_pkg::PH_TAIL_CR: begin
                    if (b != cbd_pkg::CH_CR)
                        err = 1'b1;
                    else
                        ph = cbd_pkg::PH_TAIL_LF;
                end
                default: begin
                    if (b != cbd_pkg::CH_LF) begin
                        err = 1'b1;
                    end else begin
                        if (zero_chunk) begin
                            produced  = 1'b1;
                            beat.kind = cbd_pkg::KIND_END;
                        end
                        clear_framing();
                    end
                end
            endcase
            if (err) begin
                clear_framing();
                produced  = 1'b1;
                beat.kind = cbd_pkg::KIND_ERROR;
            end
        end else if (mode_q == cbd_pkg::MODE_FIXED && len_q != 32'd0) begin
            // once the length is reached bytes vanish until length or mode is rewritten
            if (rx_count < len_q) begin
                rx_count  = rx_count + 32'd1;
                produced  = 1'b1;
                beat.data = b;
                beat.last = (rx_count == len_q);
            end
        end else begin
            produced  = 1'b1;
            beat.data = b;
        end
    endtask

    // --------------------------------------------------------------- stimulus
    task automatic send_byte(input logic [7:0] b, input t_row_chk chk,
                             input t_body_beat want);
        bit         produced;
        t_body_beat beat;
        while (!steady && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        deframe_byte(b, produced, beat);
        if (chk == CHK_TYPED)
            body_q.push_back(want);
        else if (chk == CHK_MODEL && produced)
            body_q.push_back(beat);
        sent_cnt++;
    endtask

    task automatic feed(input logic [7:0] b);
        send_byte(b, CHK_MODEL, '0);
    endtask

    // stop sending, wait for every owed beat, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (body_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cbd_pkg::CFG_FRAMING_MODE) begin
            mode_q = val[1:0];
            clear_framing();
        end else begin
            len_q = val;
            if (mode_q != cbd_pkg::MODE_CHUNKED)
                rx_count = '0;
        end
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + {4'h0, nib};
        return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
    endfunction

    // size line with optional leading zeros and extension, closed by CR LF;
    // never longer than the line limit
    task automatic send_size_line(input logic [31:0] size);
        int         digits;
        logic [7:0] b;
        digits = 1;
        while (digits < 8 && (size >> (4 * digits)) != 0)
            digits++;
        repeat ($urandom_range(2)) feed(8'h30);
        for (int k = digits - 1; k >= 0; k--)
            feed(hex_char(size[4*k +: 4], 1'($urandom_range(1))));
        if ($urandom_range(3) == 0) begin
            feed(8'h3B);
            repeat ($urandom_range(3)) begin
                b = 8'($urandom_range(255));
                if (b == cbd_pkg::CH_LF)
                    b = 8'h3D;
                feed(b);     // a CR here is a lone CR, just another ignored char
            end
        end
        feed(cbd_pkg::CH_CR);
        feed(cbd_pkg::CH_LF);
    endtask

    // --------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (body_q.size() == 0) begin
                report_mismatch("beat with nothing owed", 32'h0,
                                32'({m_tuser, m_tdata}));
            end else begin
                head_beat = body_q.pop_front();
                if (m_tdata !== head_beat.data)
                    report_mismatch("data byte", 32'(head_beat.data), 32'(m_tdata));
                if (m_tuser !== head_beat.kind)
                    report_mismatch("kind", 32'(head_beat.kind), 32'(m_tuser));
                if (m_tlast !== head_beat.last)
                    report_mismatch("last of body", 32'(head_beat.last), 32'(m_tlast));
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 18);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_chunked_body_deframer: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------- main
    initial begin
        t_stim_row   row;
        t_body_beat  want;
        logic [1:0]  mode;
        logic [31:0] len;
        logic [7:0]  b;
        int          n;
        int          rnd_start;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            case (row.op)
                ROW_MODE: begin
                    settle();
                    write_reg(cbd_pkg::CFG_FRAMING_MODE, row.val);
                end
                ROW_LEN: begin
                    settle();
                    write_reg(cbd_pkg::CFG_BODY_LENGTH, row.val);
                end
                default: begin
                    want.data = row.data;
                    want.kind = row.kind;
                    want.last = row.last;
                    send_byte(row.val[7:0], row.chk, want);
                end
            endcase
        end

        rnd_start = sent_cnt;
        while (sent_cnt - rnd_start < RANDOM_BYTES) begin
            steady = (sent_cnt - rnd_start >= 500) && (sent_cnt - rnd_start < 800);
            settle();
            n = $urandom_range(9);
            mode = (n < 5) ? cbd_pkg::MODE_CHUNKED : (n < 8) ? cbd_pkg::MODE_FIXED :
                   (n == 8) ? cbd_pkg::MODE_RAW : MODE_UNUSED;
            // sometimes keep the mode and only restart the length count
            if ($urandom_range(3) != 0)
                write_reg(cbd_pkg::CFG_FRAMING_MODE, 32'(mode));
            case ($urandom_range(4))
                0:       len = '0;
                1:       len = 32'd1;
                2:       len = '1;
                3:       len = $urandom_range(2, 40);
                default: len = $urandom;
            endcase
            write_reg(cbd_pkg::CFG_BODY_LENGTH, len);

            if (mode_q == cbd_pkg::MODE_CHUNKED) begin
                repeat ($urandom_range(3, 8)) begin
                    if ($urandom_range(99) < 80) begin
                        // well-formed body: a few chunks and a last chunk
                        repeat ($urandom_range(1, 3)) begin
                            n = ($urandom_range(99) < 85) ? $urandom_range(1, 16)
                                                          : $urandom_range(17, 80);
                            send_size_line(32'(n));
                            repeat (n) feed(8'($urandom_range(255)));
                            feed(cbd_pkg::CH_CR);
                            feed(cbd_pkg::CH_LF);
                        end
                        if ($urandom_range(3) == 0) begin
                            feed(cbd_pkg::CH_CR);
                            feed(cbd_pkg::CH_LF);
                        end else begin
                            send_size_line(32'd0);
                        end
                        feed(cbd_pkg::CH_CR);
                        feed(cbd_pkg::CH_LF);
                    end else begin
                        case ($urandom_range(3))
                            0: begin
                                // over-long line, sometimes after a maximal size
                                if ($urandom_range(1)) begin
                                    repeat (8) feed(hex_char(4'hF, 1'($urandom_range(1))));
                                    n = $urandom_range(8, 11);
                                end else begin
                                    n = $urandom_range(16, 19);
                                end
                                repeat (n) begin
                                    b = 8'($urandom_range(255));
                                    if (b == cbd_pkg::CH_LF)
                                        b = 8'h20;
                                    feed(b);
                                end
                            end
                            1: begin
                                // size that does not fit in 32 bits
                                feed(hex_char(4'($urandom_range(1, 15)),
                                              1'($urandom_range(1))));
                                repeat ($urandom_range(8, 9))
                                    feed(hex_char(4'($urandom_range(15)),
                                                  1'($urandom_range(1))));
                            end
                            2: begin
                                // broken CR LF tail, also after a zero-size line
                                n = $urandom_range(0, 4);
                                send_size_line(32'(n));
                                repeat (n) feed(8'($urandom_range(255)));
                                b = 8'($urandom_range(255));
                                if ($urandom_range(1)) begin
                                    if (b == cbd_pkg::CH_CR)
                                        b = b ^ 8'h01;
                                end else begin
                                    feed(cbd_pkg::CH_CR);
                                    if (b == cbd_pkg::CH_LF)
                                        b = b ^ 8'h01;
                                end
                                feed(b);
                            end
                            default: begin
                                repeat ($urandom_range(1, 6)) feed(8'($urandom_range(255)));
                            end
                        endcase
                    end
                end
            end else begin
                repeat ($urandom_range(10, 60)) feed(8'($urandom_range(255)));
            end
        end
        steady = 1'b0;

        settle();
        if (mismatch_cnt == 0 && body_q.size() == 0) begin
            $display("tb_chunked_body_deframer: PASS");
        end else begin
            $display("tb_chunked_body_deframer: FAIL");
        end
        $finish;
    end

endmodule

[chunked_body_deframer.f]
design/cbd_pkg.sv
design/cbd_in_stage.sv
design/cbd_core.sv
design/cbd_out_stage.sv
design/chunked_body_deframer.sv
test/tb_chunked_body_deframer.sv
